>>> src/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared widths, types and states for the segment mean / stdev block.
// ----------------------------------------------------------------------------
package smsd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int MAX_SEGMENT_LEN = 1024;
    localparam int OUT_W           = 16;

    localparam int CNT_W  = $clog2(MAX_SEGMENT_LEN + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int SSQ_W  = 2 * SAMPLE_W + CNT_W - 1;
    localparam int AMAG_W = SUM_W - 1;
    localparam int SQ_W   = 2 * AMAG_W;
    localparam int NSS_W  = SSQ_W + CNT_W;
    localparam int NN_W   = 2 * CNT_W;
    localparam int ROOT_W = (NSS_W + 1) / 2;
    localparam int DP_W   = 2 * ROOT_W;
    localparam int STEP_W = $clog2(NSS_W + 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SSQ_W-1:0]        ssq;
        logic [CNT_W-1:0]        cnt;
        logic                    ovf;
        logic                    last;
    } t_seg_job;

    typedef struct packed {
        logic signed [OUT_W-1:0] mean;
        logic [OUT_W-1:0]        stdev;
        logic                    empty_error;
        logic                    overflow;
        logic                    last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVM,
        S_DIVV,
        S_SQRT,
        S_DONE
    } t_bstate;

endpackage

>>> src/smsd_in_if.sv
// ----------------------------------------------------------------------------
// smsd_in_if
// Sample channel: valid/ready handshake with sample and segment markers.
// ----------------------------------------------------------------------------
interface smsd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [smsd_pkg::SAMPLE_W-1:0] sample;
    logic                                 sample_valid;
    logic                                 ends_segment;
    logic                                 last_segment;

    modport source (output valid, sample, sample_valid, ends_segment, last_segment,
                    input ready);
    modport sink (input valid, sample, sample_valid, ends_segment, last_segment,
                  output ready);
endinterface

>>> src/smsd_out_if.sv
// ----------------------------------------------------------------------------
// smsd_out_if
// Result channel: valid/ready handshake with per-segment statistics.
// ----------------------------------------------------------------------------
interface smsd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [smsd_pkg::OUT_W-1:0] mean;
    logic [smsd_pkg::OUT_W-1:0]        stdev;
    logic                              empty_error;
    logic                              overflow;
    logic                              last;

    modport source (output valid, mean, stdev, empty_error, overflow, last,
                    input ready);
    modport sink (input valid, mean, stdev, empty_error, overflow, last,
                  output ready);
endinterface

>>> src/smsd_front.sv
// ----------------------------------------------------------------------------
// smsd_front
// Accumulates sum, sum of squares and count; hands closed segments to queue.
// ----------------------------------------------------------------------------
module smsd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [smsd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_sample_valid,
    input  logic                                 i_ends_segment,
    input  logic                                 i_last_segment,
    output logic                                 o_push,
    output smsd_pkg::t_seg_job                   o_job,
    input  logic                                 i_full
);
    import smsd_pkg::*;

    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [SSQ_W-1:0]        r_ssq, n_ssq;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic [SAMPLE_W-1:0]     s_mag;
    logic [2*SAMPLE_W-1:0]   s_sq;
    logic                    s_take;
    logic                    s_full_cnt;

    assign o_ready    = !i_full;
    assign s_take     = i_valid && o_ready;
    assign s_full_cnt = (r_cnt >= CNT_W'(MAX_SEGMENT_LEN));
    assign s_mag      = i_sample[SAMPLE_W-1] ? SAMPLE_W'(~i_sample + 1'b1)
                                             : SAMPLE_W'(i_sample);
    assign s_sq       = s_mag * s_mag;

    always_comb begin
        n_sum = r_sum;
        n_ssq = r_ssq;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (i_sample_valid) begin
            if (s_full_cnt) begin
                n_ovf = 1'b1;
            end else begin
                n_sum = r_sum + SUM_W'(i_sample);
                n_ssq = r_ssq + SSQ_W'(s_sq);
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    assign o_push     = s_take && i_ends_segment;
    assign o_job.sum  = n_sum;
    assign o_job.ssq  = n_ssq;
    assign o_job.cnt  = n_cnt;
    assign o_job.ovf  = n_ovf;
    assign o_job.last = i_last_segment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ssq <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (s_take) begin
            if (i_ends_segment) begin
                r_sum <= '0;
                r_ssq <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_ssq <= n_ssq;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

>>> src/smsd_queue.sv
// ----------------------------------------------------------------------------
// smsd_queue
// Two-entry queue of closed segments between front and back.
// ----------------------------------------------------------------------------
module smsd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  smsd_pkg::t_seg_job   i_job,
    output logic                 o_full,
    output logic                 o_valid,
    output smsd_pkg::t_seg_job   o_job,
    input  logic                 i_pop
);
    import smsd_pkg::*;

    t_seg_job   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       s_wr, s_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_wr) r_wp <= !r_wp;
            if (s_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, s_wr} - {1'b0, s_rd};
        end
    end

endmodule

>>> src/smsd_back.sv
// ----------------------------------------------------------------------------
// smsd_back
// Sequencer: n*sumsq by shift-add, shared restoring divider, bit-pair sqrt.
// ----------------------------------------------------------------------------
module smsd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  smsd_pkg::t_seg_job   i_job,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output smsd_pkg::t_result    o_res,
    input  logic                 i_res_ready
);
    import smsd_pkg::*;

    t_bstate             r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_res_valid, n_res_valid;
    t_result             r_res, n_res;

    // datapath
    logic [CNT_W-1:0]    r_n, n_n;
    logic                r_neg, n_neg;
    logic [AMAG_W-1:0]   r_amag, n_amag;
    logic                r_ovf, n_ovf;
    logic                r_last, n_last;
    logic                r_empty, n_empty;
    logic [NSS_W-1:0]    r_mcand, n_mcand;
    logic [CNT_W-1:0]    r_mplr, n_mplr;
    logic [NSS_W-1:0]    r_nss, n_nss;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic [NN_W-1:0]     r_nn, n_nn;
    logic [NSS_W-1:0]    r_dnum, n_dnum;
    logic [NN_W-1:0]     r_den, n_den;
    logic [NN_W-1:0]     r_rem, n_rem;
    logic [OUT_W-1:0]    r_mean, n_mean;
    logic [DP_W-1:0]     r_sx, n_sx;
    logic [ROOT_W+1:0]   r_srem, n_srem;
    logic [ROOT_W-1:0]   r_root, n_root;

    logic [NN_W:0]       s_rsh;
    logic                s_dge;
    logic [NSS_W-1:0]    s_dq;
    logic [ROOT_W+1:0]   s_srsh, s_trial;
    logic                s_sge;
    logic [ROOT_W-1:0]   s_root;
    logic [NSS_W-1:0]    s_sqx;
    logic [AMAG_W-1:0]   s_jmag;

    // divider step
    assign s_rsh = {r_rem, r_dnum[NSS_W-1]};
    assign s_dge = (s_rsh >= {1'b0, r_den});
    assign s_dq  = {r_dnum[NSS_W-2:0], s_dge};

    // square root step
    assign s_srsh  = {r_srem[ROOT_W-1:0], r_sx[DP_W-1:DP_W-2]};
    assign s_trial = {r_root, 2'b01};
    assign s_sge   = (s_srsh >= s_trial);
    assign s_root  = {r_root[ROOT_W-2:0], s_sge};

    assign s_sqx  = NSS_W'(r_sq);
    assign s_jmag = i_job.sum[SUM_W-1] ? AMAG_W'(-i_job.sum) : AMAG_W'(i_job.sum);

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        n_n         = r_n;
        n_neg       = r_neg;
        n_amag      = r_amag;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_empty     = r_empty;
        n_mcand     = r_mcand;
        n_mplr      = r_mplr;
        n_nss       = r_nss;
        n_sq        = r_sq;
        n_nn        = r_nn;
        n_dnum      = r_dnum;
        n_den       = r_den;
        n_rem       = r_rem;
        n_mean      = r_mean;
        n_sx        = r_sx;
        n_srem      = r_srem;
        n_root      = r_root;
        o_pop       = 1'b0;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_n     = i_job.cnt;
                    n_neg   = i_job.sum[SUM_W-1];
                    n_amag  = s_jmag;
                    n_ovf   = i_job.ovf;
                    n_last  = i_job.last;
                    n_mcand = NSS_W'(i_job.ssq);
                    n_mplr  = i_job.cnt;
                    n_nss   = '0;
                    n_step  = '0;
                    n_mean  = '0;
                    n_root  = '0;
                    if (i_job.cnt == '0) begin
                        n_empty = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_empty = 1'b0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_mplr[0]) n_nss = r_nss + r_mcand;
                n_mcand = {r_mcand[NSS_W-2:0], 1'b0};
                n_mplr  = r_mplr >> 1;
                n_sq    = r_amag * r_amag;
                n_nn    = r_n * r_n;
                n_step  = r_step + 1'b1;
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    n_dnum  = NSS_W'(r_amag);
                    n_den   = NN_W'(r_n);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIVM;
                end
            end
            S_DIVM, S_DIVV: begin
                n_dnum = s_dq;
                n_rem  = s_dge ? NN_W'(s_rsh - {1'b0, r_den}) : NN_W'(s_rsh);
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(NSS_W - 1)) begin
                    n_step = '0;
                    if (r_state == S_DIVM) begin
                        n_mean  = r_neg ? OUT_W'(~s_dq + 1'b1) : OUT_W'(s_dq);
                        n_dnum  = (r_nss > s_sqx) ? (r_nss - s_sqx) : '0;
                        n_den   = r_nn;
                        n_rem   = '0;
                        n_state = S_DIVV;
                    end else begin
                        n_sx    = DP_W'(s_dq);
                        n_srem  = '0;
                        n_root  = '0;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                n_srem = s_sge ? (s_srsh - s_trial) : s_srsh;
                n_root = s_root;
                n_sx   = {r_sx[DP_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res_valid       = 1'b1;
                    n_res.mean        = r_mean;
                    n_res.stdev       = (|r_root[ROOT_W-1:OUT_W]) ? '1 : r_root[OUT_W-1:0];
                    n_res.empty_error = r_empty;
                    n_res.overflow    = r_ovf;
                    n_res.last        = r_last;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_n     <= n_n;
        r_neg   <= n_neg;
        r_amag  <= n_amag;
        r_ovf   <= n_ovf;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_mcand <= n_mcand;
        r_mplr  <= n_mplr;
        r_nss   <= n_nss;
        r_sq    <= n_sq;
        r_nn    <= n_nn;
        r_dnum  <= n_dnum;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_mean  <= n_mean;
        r_sx    <= n_sx;
        r_srem  <= n_srem;
        r_root  <= n_root;
    end

endmodule

>>> src/segment_mean_stdev_top.sv
// ----------------------------------------------------------------------------
// segment_mean_stdev_top
// Per-segment mean and population standard deviation of Q3.12 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle and accumulated in the front end; a
// transaction with ends_segment set closes the segment and hands its sums to a
// two-entry queue. The back end turns each closed segment into one result:
// mean = sum/n truncated toward zero, stdev = floor(sqrt((n*sumsq-sum^2)/n^2))
// clamped to 16 bits. A segment runs the shift-add n*sumsq, two passes of the
// shared restoring divider (mean, then variance) and a bit-pair square root;
// an empty segment goes straight to the result. Sample input stalls only when
// the queue holds two segments still waiting for the back end.
module segment_mean_stdev_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smsd_in_if.sink     i_sample_ch,
    smsd_out_if.source  o_result_ch
);
    import smsd_pkg::*;

    logic     s_push, s_full, s_qvalid, s_pop, s_res_valid;
    t_seg_job s_fjob, s_qjob;
    t_result  s_res;

    smsd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_sample_ch.valid),
        .o_ready        (i_sample_ch.ready),
        .i_sample       (i_sample_ch.sample),
        .i_sample_valid (i_sample_ch.sample_valid),
        .i_ends_segment (i_sample_ch.ends_segment),
        .i_last_segment (i_sample_ch.last_segment),
        .o_push         (s_push),
        .o_job          (s_fjob),
        .i_full         (s_full)
    );

    smsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_fjob),
        .o_full  (s_full),
        .o_valid (s_qvalid),
        .o_job   (s_qjob),
        .i_pop   (s_pop)
    );

    smsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_qvalid),
        .i_job       (s_qjob),
        .o_pop       (s_pop),
        .o_res_valid (s_res_valid),
        .o_res       (s_res),
        .i_res_ready (o_result_ch.ready)
    );

    assign o_result_ch.valid       = s_res_valid;
    assign o_result_ch.mean        = s_res.mean;
    assign o_result_ch.stdev       = s_res.stdev;
    assign o_result_ch.empty_error = s_res.empty_error;
    assign o_result_ch.overflow    = s_res.overflow;
    assign o_result_ch.last        = s_res.last;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Segment mean / stdev testbench: directed table, one overflowing segment and random segments,
// checked against an integer predictor of the per-segment statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import smsd_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               ends_segment;
        logic               last_segment;
        logic               has_exp;   // typed-in result present
        t_result            exp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_fail = 0;
    int   n_results = 0;
    int   n_items = 0;
    bit   idle_off = 1'b0;

    smsd_in_if  sample_ch ();
    smsd_out_if result_ch ();

    segment_mean_stdev_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch.sink),
        .o_result_ch (result_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    longint            seg_sum;
    longint unsigned   seg_ssq;
    int                seg_cnt;
    bit                seg_ovf;
    t_result           stats_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= x) root = probe;
        end
        return root;
    endfunction

    // Accumulate one transaction; returns 1 with the stats when a segment closes.
    function automatic bit predict_segment(logic signed [15:0] s, logic sv, logic es,
                                           logic ls, output t_result r);
        longint          sv64;
        longint unsigned amag, nss, d, rt, n;
        longint          m;
        r = '0;
        if (sv) begin
            if (seg_cnt >= MAX_SEGMENT_LEN) seg_ovf = 1'b1;
            else begin
                sv64 = s;
                seg_sum += sv64;
                seg_ssq += (sv64 < 0 ? -sv64 : sv64) * (sv64 < 0 ? -sv64 : sv64);
                seg_cnt++;
            end
        end
        if (!es) return 1'b0;
        if (seg_cnt == 0) r.empty_error = 1'b1;
        else begin
            n = seg_cnt;
            m = seg_sum / longint'(n);
            r.mean = m[15:0];
            amag = seg_sum < 0 ? -seg_sum : seg_sum;
            nss = n * seg_ssq;
            d = (nss > amag * amag) ? nss - amag * amag : 0;
            rt = int_sqrt(d / (n * n));
            r.stdev = rt > 65535 ? 16'hFFFF : rt[15:0];
        end
        r.overflow = seg_ovf;
        r.last = ls;
        seg_sum = 0; seg_ssq = 0; seg_cnt = 0; seg_ovf = 0;
        return 1'b1;
    endfunction

    task automatic send_item(logic signed [15:0] s, logic sv, logic es, logic ls);
        t_result r;
        if (!idle_off && $urandom_range(0, 7) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample       <= s;
        sample_ch.sample_valid <= sv;
        sample_ch.ends_segment <= es;
        sample_ch.last_segment <= ls;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        if (predict_segment(s, sv, es, ls, r)) stats_q.push_back(r);
        n_items++;
        @(negedge i_clk);
    endtask

    // result side: random stall bursts, compare at the rising edge
    initial begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) stall--;
            else if (!idle_off && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 14);
            result_ch.ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            n_results++;
            if (stats_q.size() == 0) begin
                $error("result with no expected segment");
                n_fail++;
            end else begin
                e = stats_q.pop_front();
                if (result_ch.mean !== e.mean) begin
                    $error("mean exp %0d got %0d", e.mean, result_ch.mean); n_fail++;
                end
                if (result_ch.stdev !== e.stdev) begin
                    $error("stdev exp %0d got %0d", e.stdev, result_ch.stdev); n_fail++;
                end
                if (result_ch.empty_error !== e.empty_error) begin
                    $error("empty_error exp %0b got %0b", e.empty_error,
                           result_ch.empty_error);
                    n_fail++;
                end
                if (result_ch.overflow !== e.overflow) begin
                    $error("overflow exp %0b got %0b", e.overflow, result_ch.overflow);
                    n_fail++;
                end
                if (result_ch.last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, result_ch.last); n_fail++;
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        t_stim_row table_rows[$];
        t_stim_row row;
        t_result   pr;
        int        len;
        int        mode;
        logic signed [15:0] s;
        longint            keep_sum;
        longint unsigned   keep_ssq;
        int                keep_cnt;
        bit                keep_ovf;
        seg_sum = 0; seg_ssq = 0; seg_cnt = 0; seg_ovf = 0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sample_ch.sample_valid = 1'b0;
        sample_ch.ends_segment = 1'b0;
        sample_ch.last_segment = 1'b0;

        // directed rows: {sample, sv, es, ls, has_exp, exp}
        table_rows.push_back('{16'sd0, 0, 1, 0, 1, '{0, 0, 1, 0, 0}});  // empty after reset
        table_rows.push_back('{16'sd0, 0, 1, 1, 1, '{0, 0, 1, 0, 1}});
        table_rows.push_back('{16'sh7FFF, 1, 1, 0, 1, '{16'sh7FFF, 0, 0, 0, 0}});
        table_rows.push_back('{-16'sd32768, 1, 1, 1, 1, '{-16'sd32768, 0, 0, 0, 1}});
        table_rows.push_back('{16'sh7FFF, 1, 0, 1, 0, '0});             // last ignored
        table_rows.push_back('{-16'sd32768, 1, 1, 0, 0, '0});           // max spread
        table_rows.push_back('{-16'sd3, 1, 0, 0, 0, '0});
        table_rows.push_back('{16'sd1, 1, 0, 0, 0, '0});
        table_rows.push_back('{16'sd1234, 0, 1, 0, 0, '0});             // close with sample ignored
        table_rows.push_back('{16'sd5, 1, 0, 0, 0, '0});
        table_rows.push_back('{16'sd5, 1, 0, 0, 0, '0});
        table_rows.push_back('{16'sd5, 1, 1, 1, 1, '{16'sd5, 0, 0, 0, 1}});
        table_rows.push_back('{16'shAAAA, 1, 0, 0, 0, '0});
        table_rows.push_back('{16'sh5555, 1, 1, 0, 0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (table_rows[i]) begin
            row = table_rows[i];
            if (row.has_exp) begin
                keep_sum = seg_sum; keep_ssq = seg_ssq;
                keep_cnt = seg_cnt; keep_ovf = seg_ovf;
                void'(predict_segment(row.sample, row.sample_valid, row.ends_segment,
                                      row.last_segment, pr));
                // restore state touched by the lookahead; predictor is rerun in send_item
                seg_sum = keep_sum; seg_ssq = keep_ssq;
                seg_cnt = keep_cnt; seg_ovf = keep_ovf;
                if (pr !== row.exp) begin
                    $error("table row %0d expectation mismatch", i); n_fail++;
                end
            end
            send_item(row.sample, row.sample_valid, row.ends_segment, row.last_segment);
        end

        // one segment long enough to overflow the count
        for (int k = 0; k < MAX_SEGMENT_LEN + 3; k++)
            send_item(16'($urandom), 1'b1, 1'b0, 1'b0);
        send_item(16'($urandom), 1'b1, 1'b1, 1'b0);

        // hold off until every result has drained
        sample_ch.valid <= 1'b0;
        while (stats_q.size() != 0) @(negedge i_clk);

        while (n_items < 1950) begin
            mode = $urandom_range(0, 9);
            len = (mode == 0) ? 0 : $urandom_range(1, 12);
            if (n_items > 1950 - 150) idle_off = 1'b1;
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 3))
                    0: s = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768;
                    1: s = 16'(int'($urandom_range(0, 8191)) - 4096);
                    default: s = 16'($urandom);
                endcase
                send_item(s, $urandom_range(0, 7) != 0, 1'b0, 1'($urandom_range(0, 1)));
            end
            send_item(16'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                      1'($urandom_range(0, 1)));
        end
        sample_ch.valid <= 1'b0;

        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Drove %0d sample transactions, checked %0d segment results,", n_items,
                 n_results);
        $display("including empty, saturated-count and full-scale segments.");
        if (n_fail == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule
